// File: src/ssl_pkg.sv
// shared types and constants for the scaled sprite luma threshold block
package ssl_pkg;

  localparam int SPRITE_WIDTH  = 64;
  localparam int SPRITE_HEIGHT = 64;

  localparam int STORE_AW    = 12;
  localparam int STORE_DEPTH = 1 << STORE_AW;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);

  localparam int APB_AW = 5;

  // luma weights, scaled by LUMA_DIV
  localparam logic [17:0] LUMA_R   = 18'd299;
  localparam logic [17:0] LUMA_G   = 18'd587;
  localparam logic [17:0] LUMA_B   = 18'd114;
  localparam logic [17:0] LUMA_DIV = 18'd1000;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [2:0] REG_DEST_WIDTH  = 3'd0;
  localparam logic [2:0] REG_DEST_HEIGHT = 3'd1;
  localparam logic [2:0] REG_ORIGIN_X    = 3'd2;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd3;
  localparam logic [2:0] REG_LUMA_THR    = 3'd4;

  localparam logic [7:0]  RST_DEST_WIDTH  = 8'd96;
  localparam logic [7:0]  RST_DEST_HEIGHT = 8'd96;
  localparam logic [7:0]  RST_LUMA_THR    = 8'd28;

  typedef struct packed {
    logic        func;
    logic [11:0] load_addr;
    logic [15:0] load_pixel;
    logic [7:0]  dest_row;
    logic [7:0]  dest_col;
  } ssl_cmd_t;

  typedef struct packed {
    logic               pixel_on;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
  } ssl_rsp_t;

  typedef struct packed {
    logic [7:0]         dest_width;
    logic [7:0]         dest_height;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [7:0]         luma_threshold;
  } ssl_cfg_t;

  // classified transaction handed from front to back
  typedef struct packed {
    logic                is_load;
    logic                in_range;
    logic [STORE_AW-1:0] load_addr;
    logic [15:0]         load_pixel;
    logic [7:0]          dest_row;
    logic [7:0]          dest_col;
    logic signed [15:0]  pixel_x;
    logic signed [15:0]  pixel_y;
  } ssl_job_t;

endpackage

// File: src/ssl_div.sv
// serial restoring divider, one quotient bit per cycle, quotient known to fit 8 bits
module ssl_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] num,
  input  logic [7:0]  den,
  output logic        busy,
  output logic [7:0]  quo
);
  import ssl_pkg::*;

  logic [7:0] rem;
  logic [7:0] sh;
  logic [2:0] cnt;
  logic [8:0] trial;
  logic       ge;

  // upper numerator byte is already below den, so eight steps suffice
  assign trial = {rem, sh[7]};
  assign ge    = trial >= {1'b0, den};
  assign quo   = sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 3'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 3'd0;
      rem  <= num[15:8];
      sh   <= num[7:0];
    end else if (busy) begin
      rem <= ge ? 8'(trial - {1'b0, den}) : trial[7:0];
      sh  <= {sh[6:0], ge};
      cnt <= cnt + 3'd1;
      if (cnt == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// File: src/ssl_fifo.sv
// short transaction queue between front and back
module ssl_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ssl_pkg::ssl_job_t wdata,
  input  logic              pop,
  output ssl_pkg::ssl_job_t rdata,
  output logic              full,
  output logic              empty
);
  import ssl_pkg::*;

  ssl_job_t           slots [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wptr;
  logic [FIFO_PW-1:0] rptr;
  logic [FIFO_PW:0]   count;

  assign full  = count == (FIFO_PW+1)'(FIFO_DEPTH);
  assign empty = count == '0;
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: src/ssl_front.sv
// front end: register file, command accept and classification
module ssl_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  ssl_pkg::ssl_cmd_t           cmd,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssl_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output ssl_pkg::ssl_cfg_t           cfg,
  input  logic                        full,
  output logic                        push,
  output ssl_pkg::ssl_job_t           job
);
  import ssl_pkg::*;

  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dest_width     <= RST_DEST_WIDTH;
      cfg.dest_height    <= RST_DEST_HEIGHT;
      cfg.origin_x       <= '0;
      cfg.origin_y       <= '0;
      cfg.luma_threshold <= RST_LUMA_THR;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DEST_WIDTH:  cfg.dest_width     <= pwdata[7:0];
        REG_DEST_HEIGHT: cfg.dest_height    <= pwdata[7:0];
        REG_ORIGIN_X:    cfg.origin_x       <= pwdata[15:0];
        REG_ORIGIN_Y:    cfg.origin_y       <= pwdata[15:0];
        REG_LUMA_THR:    cfg.luma_threshold <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEST_WIDTH:  prdata = {24'd0, cfg.dest_width};
      REG_DEST_HEIGHT: prdata = {24'd0, cfg.dest_height};
      REG_ORIGIN_X:    prdata = {16'd0, cfg.origin_x};
      REG_ORIGIN_Y:    prdata = {16'd0, cfg.origin_y};
      REG_LUMA_THR:    prdata = {24'd0, cfg.luma_threshold};
      default:         prdata = '0;
    endcase
  end

  assign busy = full;
  assign push = start && !full;

  always_comb begin
    job.is_load    = cmd.func == FUNC_LOAD;
    job.load_addr  = cmd.load_addr;
    job.load_pixel = cmd.load_pixel;
    job.dest_row   = cmd.dest_row;
    job.dest_col   = cmd.dest_col;
    job.in_range   = cfg.dest_width != 8'd0 && cfg.dest_height != 8'd0
                     && cmd.dest_row < cfg.dest_height && cmd.dest_col < cfg.dest_width;
    if (cmd.func == FUNC_LOAD) begin
      job.pixel_x = '0;
      job.pixel_y = '0;
    end else begin
      job.pixel_x = cfg.origin_x + $signed({8'd0, cmd.dest_col});
      job.pixel_y = cfg.origin_y + $signed({8'd0, cmd.dest_row});
    end
  end

endmodule

// File: src/ssl_back.sv
// back end: sprite memory, scale dividers, luma test and result register
module ssl_back (
  input  logic              clk,
  input  logic              rst,
  input  ssl_pkg::ssl_cfg_t cfg,
  input  logic              empty,
  input  ssl_pkg::ssl_job_t head,
  output logic              pop,
  output logic              done,
  output ssl_pkg::ssl_rsp_t rsp
);
  import ssl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_SUM,
    S_CMP
  } state_t;

  state_t state;

  logic [15:0]         mem [STORE_DEPTH];
  logic [15:0]         rd_data;
  logic [STORE_AW-1:0] rd_addr;
  logic                wr_en;

  ssl_job_t    job;
  logic        div_start;
  logic        row_busy;
  logic        col_busy;
  logic [7:0]  srow;
  logic [7:0]  scol;
  logic [15:0] row_num;
  logic [15:0] col_num;
  logic [19:0] idx_full;
  logic [17:0] luma_sum;
  logic        nonzero;
  logic [17:0] thr_scaled;

  assign pop       = state == S_IDLE && !empty;
  assign wr_en     = pop && head.is_load;
  assign div_start = pop && !head.is_load && head.in_range;

  assign row_num = 16'(head.dest_row) * 16'(SPRITE_HEIGHT);
  assign col_num = 16'(head.dest_col) * 16'(SPRITE_WIDTH);

  ssl_div u_row_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (row_num),
    .den   (cfg.dest_height),
    .busy  (row_busy),
    .quo   (srow)
  );

  ssl_div u_col_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (col_num),
    .den   (cfg.dest_width),
    .busy  (col_busy),
    .quo   (scol)
  );

  // raster index wraps to the store size
  assign idx_full   = 20'(srow) * 20'(SPRITE_WIDTH) + 20'(scol);
  assign thr_scaled = 18'(cfg.luma_threshold) * LUMA_DIV;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[head.load_addr] <= head.load_pixel;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!empty) begin
            job <= head;
            if (head.is_load || !head.in_range) begin
              done         <= 1'b1;
              rsp.pixel_on <= 1'b0;
              rsp.pixel_x  <= head.pixel_x;
              rsp.pixel_y  <= head.pixel_y;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (!row_busy && !col_busy) begin
            rd_addr <= idx_full[STORE_AW-1:0];
            state   <= S_RD;
          end
        end
        S_RD: begin
          state <= S_SUM;
        end
        S_SUM: begin
          luma_sum <= 18'({rd_data[15:11], 3'd0}) * LUMA_R
                    + 18'({rd_data[10:5], 2'd0}) * LUMA_G
                    + 18'({rd_data[4:0], 3'd0}) * LUMA_B;
          nonzero  <= rd_data != 16'd0;
          state    <= S_CMP;
        end
        S_CMP: begin
          // floor(sum / 1000) >= thr is the same as sum >= 1000 * thr
          done         <= 1'b1;
          rsp.pixel_on <= nonzero && luma_sum >= thr_scaled;
          rsp.pixel_x  <= job.pixel_x;
          rsp.pixel_y  <= job.pixel_y;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/scaled_sprite_luma_threshold.sv
// top level of the scaled sprite luma threshold block
// Usage: a command transaction is taken at a rising edge where start is high
// and busy is low. func selects a sprite word load (load_addr, load_pixel) or
// a destination pixel query (dest_row, dest_col). Each transaction yields one
// result on rsp, valid for exactly one cycle while done is high; the receiver
// cannot stall, so results are never held back.
// A load gives an all-zero result and writes the 4096-word sprite memory. A
// query inside the destination goes through the queue, a step that loads the
// two serial row and column dividers running side by side, eight divide steps,
// a step that forms the address, then memory read, luma sum and compare.
// Unlit queries (outside the destination or zero size) skip the divide.
// Queries are handled one at a time by the back end, which holds each
// in-range query through its divide, read, sum and compare; a two-entry queue
// lets the front keep taking commands meanwhile, and busy rises only when it
// is full.
// Registers are set over the APB port, at byte address 4 * index, and must be
// written only while no transaction is pending. Reset loads the register
// defaults and empties the queue; sprite memory contents are not cleared.
module scaled_sprite_luma_threshold (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  ssl_pkg::ssl_cmd_t          cmd,
  output logic                       done,
  output ssl_pkg::ssl_rsp_t          rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ssl_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import ssl_pkg::*;

  ssl_cfg_t cfg;
  ssl_job_t push_job;
  ssl_job_t head_job;
  logic     push;
  logic     pop;
  logic     full;
  logic     empty;

  ssl_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .full    (full),
    .push    (push),
    .job     (push_job)
  );

  ssl_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_job),
    .pop   (pop),
    .rdata (head_job),
    .full  (full),
    .empty (empty)
  );

  ssl_back u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .empty (empty),
    .head  (head_job),
    .pop   (pop),
    .done  (done),
    .rsp   (rsp)
  );

endmodule

// File: tb/sv/tb_scaled_sprite_luma_threshold.sv
// self-checking testbench for the scaled sprite luma threshold block
module tb_scaled_sprite_luma_threshold;
  import ssl_pkg::*;

  localparam int IDLE_LIMIT      = 1000;
  localparam int ITEMS_PER_PHASE = 205;
  localparam int SETTLE_CYCLES   = 20;

  // mirror of the sprite memory and registers, holds the pixels still owed by the block
  class sprite_mirror;
    logic [15:0] words [STORE_DEPTH];
    bit          written [STORE_DEPTH];
    logic [7:0]  wid, hgt, thr;
    logic [15:0] org_x, org_y;
    ssl_rsp_t    pending_pixels [$];
    int          errors;

    function new();
      wid = RST_DEST_WIDTH;
      hgt = RST_DEST_HEIGHT;
      org_x = '0;
      org_y = '0;
      thr = RST_LUMA_THR;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_DEST_WIDTH:  wid = val[7:0];
        REG_DEST_HEIGHT: hgt = val[7:0];
        REG_ORIGIN_X:    org_x = val[15:0];
        REG_ORIGIN_Y:    org_y = val[15:0];
        REG_LUMA_THR:    thr = val[7:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [2:0] idx);
      case (idx)
        REG_DEST_WIDTH:  return {24'd0, wid};
        REG_DEST_HEIGHT: return {24'd0, hgt};
        REG_ORIGIN_X:    return {16'd0, org_x};
        REG_ORIGIN_Y:    return {16'd0, org_y};
        REG_LUMA_THR:    return {24'd0, thr};
        default:         return '0;
      endcase
    endfunction

    // sprite word that a destination pixel samples, -1 when nothing is read
    function int source_index(logic [7:0] row, logic [7:0] col);
      int srow, scol;
      if (wid == 0 || hgt == 0 || row >= hgt || col >= wid) return -1;
      srow = (int'(row) * SPRITE_HEIGHT) / int'(hgt);
      scol = (int'(col) * SPRITE_WIDTH) / int'(wid);
      return (srow * SPRITE_WIDTH + scol) % STORE_DEPTH;
    endfunction

    function int luma(logic [15:0] p);
      int r8, g8, b8;
      r8 = int'(p[15:11]) * 8;
      g8 = int'(p[10:5]) * 4;
      b8 = int'(p[4:0]) * 8;
      return (r8 * int'(LUMA_R) + g8 * int'(LUMA_G) + b8 * int'(LUMA_B)) / int'(LUMA_DIV);
    endfunction

    function void take_cmd(ssl_cmd_t c);
      ssl_rsp_t r;
      int src;
      r = '0;
      if (c.func == FUNC_LOAD) begin
        words[c.load_addr] = c.load_pixel;
        written[c.load_addr] = 1'b1;
      end else begin
        src = source_index(c.dest_row, c.dest_col);
        if (src >= 0) r.pixel_on = (words[src] != 0) && (luma(words[src]) >= int'(thr));
        r.pixel_x = org_x + {8'd0, c.dest_col};
        r.pixel_y = org_y + {8'd0, c.dest_row};
      end
      pending_pixels.push_back(r);
    endfunction

    function void match_pixel(ssl_rsp_t got);
      ssl_rsp_t want;
      if (pending_pixels.size() == 0) begin
        $display("%0t unexpected result: expected none, got on %0b x %0d y %0d",
                 $time, got.pixel_on, got.pixel_x, got.pixel_y);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      if (got.pixel_on !== want.pixel_on) begin
        $display("%0t pixel_on expected %0b got %0b", $time, want.pixel_on, got.pixel_on);
        errors++;
      end
      if (got.pixel_x !== want.pixel_x) begin
        $display("%0t pixel_x expected %0d got %0d", $time, want.pixel_x, got.pixel_x);
        errors++;
      end
      if (got.pixel_y !== want.pixel_y) begin
        $display("%0t pixel_y expected %0d got %0d", $time, want.pixel_y, got.pixel_y);
        errors++;
      end
    endfunction
  endclass

  logic              clk, rst, start, busy, done;
  logic              psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [31:0]       pwdata, prdata;
  ssl_cmd_t          cmd;
  ssl_rsp_t          rsp;

  sprite_mirror mirror;
  int           items_sent = 0;
  int           idle_cycles = 0;
  bit           burst = 1'b0;

  scaled_sprite_luma_threshold uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) mirror.match_pixel(rsp);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL scaled_sprite_luma_threshold");
      $finish;
    end
  end

  function automatic logic [15:0] rand_pixel();
    return ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom);
  endfunction

  function automatic ssl_cmd_t load_cmd(logic [11:0] a, logic [15:0] p);
    ssl_cmd_t c;
    c.func = FUNC_LOAD;
    c.load_addr = a;
    c.load_pixel = p;
    c.dest_row = 8'($urandom);
    c.dest_col = 8'($urandom);
    return c;
  endfunction

  function automatic ssl_cmd_t query_cmd(logic [7:0] row, logic [7:0] col);
    ssl_cmd_t c;
    c.func = FUNC_QUERY;
    c.load_addr = 12'($urandom);
    c.load_pixel = 16'($urandom);
    c.dest_row = row;
    c.dest_col = col;
    return c;
  endfunction

  // one command transaction, after an optional idle gap
  task automatic issue(ssl_cmd_t c);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    mirror.take_cmd(c);
    items_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (mirror.pending_pixels.size() != 0);
  endtask

  // one apb transfer, left selected so that calls run back to back; the caller returns the bus to idle
  task automatic reg_xfer(logic [2:0] idx, logic wr, logic [31:0] val, output logic [31:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    if (wr) mirror.set_reg(idx, val);
  endtask

  task automatic check_regs();
    logic [31:0] rd, mask;
    for (int i = REG_DEST_WIDTH; i <= REG_LUMA_THR; i++) begin
      reg_xfer(3'(i), 1'b0, '0, rd);
      mask = (3'(i) == REG_ORIGIN_X || 3'(i) == REG_ORIGIN_Y) ? 32'hFFFF : 32'hFF;
      if ((rd & mask) !== mirror.reg_value(3'(i))) begin
        $display("%0t register %0d readback expected %0h got %0h",
                 $time, i, mirror.reg_value(3'(i)), rd & mask);
        mirror.errors++;
      end
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_setting(logic [7:0] w, logic [7:0] h, logic [15:0] ox,
                               logic [15:0] oy, logic [7:0] th);
    logic [31:0] vals [5];
    logic [31:0] rd;
    wait_drained();
    vals[REG_DEST_WIDTH] = {24'd0, w};
    vals[REG_DEST_HEIGHT] = {24'd0, h};
    vals[REG_ORIGIN_X] = {16'd0, ox};
    vals[REG_ORIGIN_Y] = {16'd0, oy};
    vals[REG_LUMA_THR] = {24'd0, th};
    for (int i = REG_DEST_WIDTH; i <= REG_LUMA_THR; i++) reg_xfer(3'(i), 1'b1, vals[i], rd);
    check_regs();
  endtask

  task automatic directed_items();
    // reset geometry 96x96: (0,0) samples word 0, (2,2) word 65, (3,3) word 130,
    // (95,95) word 4095
    issue(load_cmd(12'd0, 16'hFFFF));
    issue(query_cmd(8'd0, 8'd0));
    issue(load_cmd(12'd4095, 16'h0001));
    issue(query_cmd(8'd95, 8'd95));
    // green only, luma right at the reset threshold, then just below it
    issue(load_cmd(12'd65, 16'h0180));
    issue(query_cmd(8'd2, 8'd2));
    issue(load_cmd(12'd65, 16'h0160));
    issue(query_cmd(8'd2, 8'd2));
    // transparent word
    issue(load_cmd(12'd130, 16'h0000));
    issue(query_cmd(8'd3, 8'd3));
    // outside the destination
    issue(query_cmd(8'd96, 8'd0));
    issue(query_cmd(8'd0, 8'd96));
    issue(query_cmd(8'd255, 8'd255));
    // zero threshold: transparent stays dark, dim word lights, coordinates wrap
    apply_setting(8'd96, 8'd96, 16'h7FFF, 16'h8000, 8'd0);
    issue(query_cmd(8'd3, 8'd3));
    issue(query_cmd(8'd95, 8'd95));
    issue(query_cmd(8'd255, 8'd255));
    // zero size on each axis
    apply_setting(8'd0, 8'd96, 16'h0000, 16'h0000, 8'd28);
    issue(query_cmd(8'd0, 8'd0));
    apply_setting(8'd96, 8'd0, 16'h0000, 16'h0000, 8'd28);
    issue(query_cmd(8'd0, 8'd0));
    // brightest word stays below the top threshold
    apply_setting(8'd96, 8'd96, 16'h0000, 16'h0000, 8'd255);
    issue(query_cmd(8'd0, 8'd0));
  endtask

  task automatic random_item();
    ssl_cmd_t c;
    int pick, src;
    c = query_cmd(8'($urandom), 8'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      c = load_cmd(12'($urandom), rand_pixel());
    end else if (pick < 85 && mirror.wid != 0 && mirror.hgt != 0) begin
      c.dest_row = 8'($urandom_range(0, int'(mirror.hgt) - 1));
      c.dest_col = 8'($urandom_range(0, int'(mirror.wid) - 1));
    end
    if (c.func == FUNC_QUERY) begin
      // never sample a word that was not loaded yet
      src = mirror.source_index(c.dest_row, c.dest_col);
      if (src >= 0 && !mirror.written[src]) issue(load_cmd(12'(src), rand_pixel()));
    end
    issue(c);
  endtask

  initial begin
    int phase_end;
    mirror = new();
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    check_regs();
    directed_items();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: apply_setting(8'd96, 8'd96, 16'h0000, 16'h0000, 8'd28);
        1: apply_setting(8'd255, 8'd255, 16'h8000, 16'h7FFF, 8'd0);
        2: apply_setting(8'd1, 8'd1, 16'h7FFF, 16'h8000, 8'd255);
        3: apply_setting(8'd0, 8'd64, 16'($urandom), 16'($urandom), 8'($urandom_range(0, 200)));
        4: apply_setting(8'd64, 8'd0, 16'($urandom), 16'($urandom), 8'($urandom_range(0, 200)));
        5: apply_setting(8'd64, 8'd64, 16'($urandom), 16'($urandom), 8'($urandom_range(0, 160)));
        6: apply_setting(8'd200, 8'd37, 16'($urandom), 16'($urandom), 8'($urandom_range(0, 200)));
        7: apply_setting(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                         16'($urandom), 16'($urandom), 8'($urandom_range(0, 200)));
        default: apply_setting(8'd255, 8'd1, 16'($urandom), 16'($urandom),
                               8'($urandom_range(0, 200)));
      endcase
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) begin
        // alternate stretches of back-to-back commands with gapped ones
        if ($urandom_range(0, 29) == 0) burst = !burst;
        if ($urandom_range(0, 79) == 0) wait_drained();
        random_item();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mirror.errors == 0 && mirror.pending_pixels.size() == 0) begin
      $display("PASS scaled_sprite_luma_threshold");
    end else begin
      $display("FAIL scaled_sprite_luma_threshold");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/ssl_pkg.sv
src/ssl_div.sv
src/ssl_fifo.sv
src/ssl_front.sv
src/ssl_back.sv
src/scaled_sprite_luma_threshold.sv
tb/sv/tb_scaled_sprite_luma_threshold.sv
